[rtl/ptm_pkg.sv]
// Package of shared constants, types and the control store of the page table map engine.
package ptm_pkg;

    localparam int POOL_FRAMES       = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int LEVELS            = 4;

    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int ENTRY_W = 64;
    localparam int PBF_W   = 40;
    localparam int IDX_W   = 9;

    localparam int FRAME_W = $clog2(POOL_FRAMES);
    localparam int NF_W    = $clog2(POOL_FRAMES + 1);
    localparam int NEED_W  = NF_W + 1;
    localparam int LVL_W   = $clog2(LEVELS + 1);
    localparam int SLOT_W  = FRAME_W + IDX_W;
    localparam int DEPTH   = POOL_FRAMES * ENTRIES_PER_TABLE;

    localparam logic [ENTRY_W-1:0] BIT_PRESENT  = 64'h1;
    localparam logic [ENTRY_W-1:0] BIT_WRITABLE = 64'h2;

    localparam int OP_W   = 3;
    localparam int COND_W = 3;
    localparam int STEP_W = 4;

    localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
    localparam logic [OP_W-1:0] OP_READ  = 3'd2;
    localparam logic [OP_W-1:0] OP_EVAL  = 3'd3;
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd4;
    localparam logic [OP_W-1:0] OP_LEAF  = 3'd5;
    localparam logic [OP_W-1:0] OP_FAIL  = 3'd6;
    localparam logic [OP_W-1:0] OP_PUSH  = 3'd7;

    localparam logic [COND_W-1:0] C_NEVER     = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS    = 3'd1;
    localparam logic [COND_W-1:0] C_NOT_START = 3'd2;
    localparam logic [COND_W-1:0] C_FAIL      = 3'd3;
    localparam logic [COND_W-1:0] C_PRESENT   = 3'd4;
    localparam logic [COND_W-1:0] C_LVL_GT1   = 3'd5;
    localparam logic [COND_W-1:0] C_LVL_GT2   = 3'd6;
    localparam logic [COND_W-1:0] C_OUT_FREE  = 3'd7;

    localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] ST_READ  = 4'd1;
    localparam logic [STEP_W-1:0] ST_EVAL  = 4'd2;
    localparam logic [STEP_W-1:0] ST_TEST  = 4'd3;
    localparam logic [STEP_W-1:0] ST_ALLOC = 4'd4;
    localparam logic [STEP_W-1:0] ST_DESC  = 4'd5;
    localparam logic [STEP_W-1:0] ST_LEAF  = 4'd6;
    localparam logic [STEP_W-1:0] ST_PUSH  = 4'd7;
    localparam logic [STEP_W-1:0] ST_HOLD  = 4'd8;
    localparam logic [STEP_W-1:0] ST_FAIL  = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } t_cw;

    typedef struct packed {
        logic start;
        logic fail;
        logic present;
        logic lvl_gt1;
        logic lvl_gt2;
        logic out_free;
    } t_dp_stat;

    // A jump is taken when the condition holds; otherwise the step counter advances.
    function automatic t_cw f_ucode(input logic [STEP_W-1:0] step);
        t_cw cw;
        unique case (step)
            ST_IDLE:  cw = '{op: OP_LOAD,  cond: C_NOT_START, target: ST_IDLE};
            ST_READ:  cw = '{op: OP_READ,  cond: C_NEVER,     target: ST_IDLE};
            ST_EVAL:  cw = '{op: OP_EVAL,  cond: C_FAIL,      target: ST_FAIL};
            ST_TEST:  cw = '{op: OP_NOP,   cond: C_PRESENT,   target: ST_DESC};
            ST_ALLOC: cw = '{op: OP_ALLOC, cond: C_LVL_GT2,   target: ST_ALLOC};
            ST_DESC:  cw = '{op: OP_NOP,   cond: C_LVL_GT1,   target: ST_READ};
            ST_LEAF:  cw = '{op: OP_LEAF,  cond: C_NEVER,     target: ST_IDLE};
            ST_PUSH:  cw = '{op: OP_PUSH,  cond: C_OUT_FREE,  target: ST_IDLE};
            ST_HOLD:  cw = '{op: OP_NOP,   cond: C_ALWAYS,    target: ST_PUSH};
            ST_FAIL:  cw = '{op: OP_FAIL,  cond: C_ALWAYS,    target: ST_PUSH};
            default:  cw = '{op: OP_NOP,   cond: C_ALWAYS,    target: ST_IDLE};
        endcase
        return cw;
    endfunction

    // Index bits of one level; bits at or above the top of the address read as zero.
    function automatic logic [IDX_W-1:0] f_index(input logic [VA_W-1:0] va,
                                                 input logic [LVL_W-1:0] lvl);
        logic [VA_W+IDX_W-1:0] ext;
        logic [IDX_W-1:0]      idx;
        ext = {{IDX_W{1'b0}}, va};
        idx = '0;
        for (int l = 1; l <= LEVELS; l++) begin
            if (lvl == LVL_W'(l)) begin
                idx = ext[12 + IDX_W * (l - 1) +: IDX_W];
            end
        end
        return idx;
    endfunction

endpackage

[rtl/ptm_if.sv]
// Request and response channel interfaces of the page table map engine.
interface ptm_in_if;
    logic        valid;
    logic        ready;
    logic [47:0] virt_addr;
    logic [51:0] phys_addr;
    logic [63:0] entry_flags;

    modport source (output valid, output virt_addr, output phys_addr, output entry_flags,
                    input ready);
    modport sink (input valid, input virt_addr, input phys_addr, input entry_flags,
                  output ready);
endinterface

interface ptm_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [1:0]  tables_allocated;
    logic [63:0] leaf_entry;

    modport source (output valid, output status, output tables_allocated, output leaf_entry,
                    input ready);
    modport sink (input valid, input status, input tables_allocated, input leaf_entry,
                  output ready);
endinterface

[rtl/ptm_seq.sv]
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module ptm_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ptm_pkg::t_dp_stat         i_stat,
    output logic [ptm_pkg::OP_W-1:0]  o_op,
    output logic [ptm_pkg::STEP_W-1:0] o_pc
);
    import ptm_pkg::*;

    logic [STEP_W-1:0] r_pc;
    logic [STEP_W-1:0] n_pc;
    t_cw               w_cw;
    logic              w_take;

    assign w_cw = f_ucode(r_pc);

    always_comb begin
        unique case (w_cw.cond)
            C_NEVER:     w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_NOT_START: w_take = !i_stat.start;
            C_FAIL:      w_take = i_stat.fail;
            C_PRESENT:   w_take = i_stat.present;
            C_LVL_GT1:   w_take = i_stat.lvl_gt1;
            C_LVL_GT2:   w_take = i_stat.lvl_gt2;
            C_OUT_FREE:  w_take = i_stat.out_free;
            default:     w_take = 1'b1;
        endcase
        n_pc = w_take ? w_cw.target : r_pc + STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_op = w_cw.op;
    assign o_pc = r_pc;

endmodule

[rtl/ptm_dp.sv]
// Datapath: table store with its clearing pass, walk registers, frame allocator, result register.
module ptm_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ptm_pkg::PBF_W-1:0]  i_cfg_wdata,
    input  logic [ptm_pkg::OP_W-1:0]   i_op,
    output ptm_pkg::t_dp_stat          o_stat,
    ptm_in_if.sink                     i_req,
    ptm_out_if.source                  o_rsp
);
    import ptm_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    logic               r_clr_busy;
    logic [SLOT_W-1:0]  r_clr_addr;

    logic [PBF_W-1:0]   r_pool_base;
    logic [NF_W-1:0]    r_next_free;

    logic [VA_W-1:0]    r_va;
    logic [PA_W-1:0]    r_pa;
    logic [ENTRY_W-1:0] r_flags;
    logic [LVL_W-1:0]   r_level;
    logic [FRAME_W-1:0] r_frame;
    logic [1:0]         r_taken;

    logic               r_res_status;
    logic [1:0]         r_res_taken;
    logic [ENTRY_W-1:0] r_res_leaf;

    logic               r_out_valid;
    logic               r_out_status;
    logic [1:0]         r_out_taken;
    logic [ENTRY_W-1:0] r_out_leaf;

    logic [SLOT_W-1:0]  w_slot;
    logic [PBF_W-1:0]   w_ptr_frame;
    logic               w_ptr_ok;
    logic               w_present;
    logic               w_room_short;
    logic [PBF_W-1:0]   w_new_pfn;
    logic [ENTRY_W-1:0] w_ptr_entry;
    logic [ENTRY_W-1:0] w_leaf;
    logic               w_start;
    logic               w_out_free;
    logic               w_we;
    logic [SLOT_W-1:0]  w_waddr;
    logic [ENTRY_W-1:0] w_wdata;

    assign w_slot       = {r_frame, f_index(r_va, r_level)};
    assign w_present    = r_rdata[0];
    assign w_ptr_frame  = r_rdata[51:12] - r_pool_base;
    assign w_ptr_ok     = w_ptr_frame < PBF_W'(POOL_FRAMES);
    assign w_room_short = (NEED_W'(r_next_free) + NEED_W'(r_level)) > NEED_W'(POOL_FRAMES + 1);
    assign w_new_pfn    = r_pool_base + PBF_W'(r_next_free);
    assign w_ptr_entry  = {12'b0, w_new_pfn, 12'b0} | BIT_PRESENT | BIT_WRITABLE;
    assign w_leaf       = {12'b0, r_pa[51:12], 12'b0} | r_flags | BIT_PRESENT;

    assign i_req.ready = (i_op == OP_LOAD) && !r_clr_busy;
    assign w_start     = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    assign o_stat.start    = w_start;
    assign o_stat.fail     = w_present ? !w_ptr_ok : w_room_short;
    assign o_stat.present  = w_present;
    assign o_stat.lvl_gt1  = r_level > LVL_W'(1);
    assign o_stat.lvl_gt2  = r_level > LVL_W'(2);
    assign o_stat.out_free = w_out_free;

    assign w_we    = r_clr_busy || (i_op == OP_ALLOC) || (i_op == OP_LEAF);
    assign w_waddr = r_clr_busy ? r_clr_addr : w_slot;
    assign w_wdata = r_clr_busy ? '0 : ((i_op == OP_ALLOC) ? w_ptr_entry : w_leaf);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_op == OP_READ) begin
            r_rdata <= r_mem[w_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_pool_base <= '0;
            r_next_free <= NF_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + SLOT_W'(1);
                if (r_clr_addr == SLOT_W'(DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                r_pool_base <= i_cfg_wdata;
            end
            if (i_op == OP_ALLOC) begin
                r_next_free <= r_next_free + NF_W'(1);
            end
            if ((i_op == OP_PUSH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                if (w_start) begin
                    r_va    <= i_req.virt_addr;
                    r_pa    <= i_req.phys_addr;
                    r_flags <= i_req.entry_flags;
                    r_level <= LVL_W'(LEVELS);
                    r_frame <= '0;
                    r_taken <= '0;
                end
            end
            OP_EVAL: begin
                if (w_present && w_ptr_ok) begin
                    r_frame <= w_ptr_frame[FRAME_W-1:0];
                    r_level <= r_level - LVL_W'(1);
                end
            end
            OP_ALLOC: begin
                r_frame <= r_next_free[FRAME_W-1:0];
                r_level <= r_level - LVL_W'(1);
                if (r_taken != 2'd3) begin
                    r_taken <= r_taken + 2'd1;
                end
            end
            OP_LEAF: begin
                r_res_status <= 1'b0;
                r_res_taken  <= r_taken;
                r_res_leaf   <= w_leaf;
            end
            OP_FAIL: begin
                r_res_status <= 1'b1;
                r_res_taken  <= '0;
                r_res_leaf   <= '0;
            end
            OP_PUSH: begin
                if (w_out_free) begin
                    r_out_status <= r_res_status;
                    r_out_taken  <= r_res_taken;
                    r_out_leaf   <= r_res_leaf;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_out_status;
    assign o_rsp.tables_allocated = r_out_taken;
    assign o_rsp.leaf_entry       = r_out_leaf;

endmodule

[rtl/page_table_map_engine_core.sv]
// Top level of the page table map engine: sequencer, datapath and checks.
//
//  channel  | dir | handshake    | word
//  i_req    | in  | valid/ready  | virt_addr, phys_addr, entry_flags
//  o_rsp    | out | valid/ready  | status, tables_allocated, leaf_entry
//  i_cfg    | in  | i_cfg_we     | i_cfg_wdata (pool base frame)
//
// A mapped request at four levels takes load, then read, eval, test and descend for each level
// whose entry is read and one alloc step per new table, then leaf write and result hand-off; a
// refused one ends in fail and hand-off. The table store has one port with a registered read.
// After reset a clearing pass zeroes all 32768 entries, one entry a cycle, while i_req.ready
// stays low. A finished word waits in the output register while the next request is taken.
module page_table_map_engine_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ptm_pkg::PBF_W-1:0] i_cfg_wdata,
    ptm_in_if.sink                    i_req,
    ptm_out_if.source                 o_rsp
);
    import ptm_pkg::*;

    t_dp_stat          w_stat;
    logic [OP_W-1:0]   w_op;
    logic [STEP_W-1:0] w_pc;

    ptm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_op    (w_op),
        .o_pc    (w_pc)
    );

    ptm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (w_op),
        .o_stat      (w_stat),
        .i_req       (i_req),
        .o_rsp       (o_rsp)
    );

`ifndef NO_ASSERTIONS
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |-> (w_pc == ST_IDLE))
        else $error("request taken outside the idle step");

    a_accept_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (w_pc == ST_READ))
        else $error("walk did not start after a request");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status) |->
            (o_rsp.tables_allocated == 2'd0 && o_rsp.leaf_entry == 64'd0))
        else $error("failed request reports allocation or a leaf entry");

    a_push_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pc == ST_PUSH && o_rsp.valid && !o_rsp.ready) |=> (w_pc == ST_HOLD))
        else $error("result pushed over a waiting word");
`endif

endmodule

[dv/page_table_map_engine_core_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the page table map engine: directed and random map requests checked against a shadow page table.
module page_table_map_engine_core_test;
    import ptm_pkg::*;

    localparam logic STATUS_MAPPED   = 1'b0;
    localparam logic STATUS_REFUSED  = 1'b1;
    localparam int   PAGE_SHIFT      = 12;
    localparam int   WATCHDOG_CYCLES = 600000;
    localparam int   DRAIN_CYCLES    = 24;
    localparam int   HOLD_CYCLES     = 400;
    localparam int   REPORT_LIMIT    = 10;
    localparam int   PAGE_LIST_MAX   = 512;

    typedef enum int {RX_STEADY, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_pace_t;

    typedef struct packed {
        logic               status;
        logic [1:0]         tables_allocated;
        logic [ENTRY_W-1:0] leaf_entry;
    } map_result_t;

    class map_walk_scoreboard;
        bit [ENTRY_W-1:0] shadow_tables [DEPTH];
        int unsigned      next_frame = 1;
        bit [PBF_W-1:0]   pool_base = '0;
        map_result_t      pending_results [$];
        int               fail_count = 0;
        int               mapped_count = 0;
        int               refused_count = 0;
        int               tables_taken = 0;
        int               words_checked = 0;

        function void set_pool_base(bit [PBF_W-1:0] value);
            pool_base = value;
        endfunction

        function int unsigned slot_of(int unsigned frame, bit [VA_W-1:0] va, int unsigned lvl);
            bit [63:0] wide_va;
            wide_va = 64'(va);
            return frame * ENTRIES_PER_TABLE
                   + int'(IDX_W'(wide_va >> (PAGE_SHIFT + IDX_W * (lvl - 1))));
        endfunction

        function bit [ENTRY_W-1:0] table_pointer(int unsigned frame);
            bit [PBF_W-1:0] pfn;
            pfn = pool_base + PBF_W'(frame);
            return {12'h0, pfn, 12'h0} | BIT_PRESENT | BIT_WRITABLE;
        endfunction

        function void report(string what);
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("%s", what);
            end
        endfunction

        function bit note_request(bit [VA_W-1:0] va, bit [PA_W-1:0] pa,
                                  bit [ENTRY_W-1:0] flags);
            map_result_t      res;
            int unsigned      frame;
            int unsigned      taken;
            int unsigned      lvl;
            int unsigned      avail;
            bit [ENTRY_W-1:0] entry;
            bit [ENTRY_W-1:0] leaf;
            bit [PBF_W-1:0]   pool_frame;
            bit               refused;
            frame = 0;
            taken = 0;
            refused = 1'b0;
            lvl = LEVELS;
            while (lvl > 1 && !refused) begin
                entry = shadow_tables[slot_of(frame, va, lvl)];
                if ((entry & BIT_PRESENT) != 0) begin
                    pool_frame = entry[PA_W-1:PAGE_SHIFT] - pool_base;
                    if (pool_frame >= POOL_FRAMES) begin
                        refused = 1'b1;
                    end else begin
                        frame = int'(pool_frame);
                        lvl--;
                    end
                end else begin
                    avail = (next_frame < POOL_FRAMES) ? POOL_FRAMES - next_frame : 0;
                    if (lvl - 1 > avail) begin
                        refused = 1'b1;
                    end else begin
                        for (; lvl > 1; lvl--) begin
                            shadow_tables[slot_of(frame, va, lvl)] = table_pointer(next_frame);
                            frame = next_frame;
                            next_frame++;
                            taken++;
                        end
                    end
                end
            end
            if (refused) begin
                res.status = STATUS_REFUSED;
                res.tables_allocated = 2'd0;
                res.leaf_entry = '0;
                refused_count++;
            end else begin
                leaf = BIT_PRESENT | {12'h0, pa[PA_W-1:PAGE_SHIFT], 12'h0} | flags;
                shadow_tables[slot_of(frame, va, 1)] = leaf;
                res.status = STATUS_MAPPED;
                res.tables_allocated = (taken > 3) ? 2'd3 : 2'(taken);
                res.leaf_entry = leaf;
                mapped_count++;
                tables_taken += taken;
            end
            pending_results.push_back(res);
            return !refused;
        endfunction

        function void check_result(map_result_t got);
            map_result_t want;
            words_checked++;
            if (pending_results.size() == 0) begin
                report($sformatf("Unexpected word: status %0d tables %0d leaf %h.",
                                 got.status, got.tables_allocated, got.leaf_entry));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.tables_allocated !== want.tables_allocated
                        || got.leaf_entry !== want.leaf_entry) begin
                    report($sformatf({"Word %0d mismatch: expected status %0d tables %0d ",
                                      "leaf %h, got status %0d tables %0d leaf %h."},
                                     words_checked, want.status, want.tables_allocated,
                                     want.leaf_entry, got.status, got.tables_allocated,
                                     got.leaf_entry));
                end
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void close_out();
            map_result_t want;
            while (pending_results.size() != 0) begin
                want = pending_results.pop_front();
                report($sformatf("Missing word: status %0d tables %0d leaf %h.",
                                 want.status, want.tables_allocated, want.leaf_entry));
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [PBF_W-1:0] i_cfg_wdata;

    ptm_in_if  req_if ();
    ptm_out_if rsp_if ();

    page_table_map_engine_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    map_walk_scoreboard walk_board = new();
    logic [VA_W-1:0]    mapped_pages [$];
    int                 burst_left = 0;
    int                 setting_count = 0;
    int                 words_seen = 0;
    int                 hold_index = 0;
    int                 hold_cycles;
    int                 watch_cycles;

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VA_W-1:0] pick_va();
        logic [VA_W-1:0] va;
        logic [VA_W-1:0] noise;
        logic [VA_W-1:0] lower;
        int unsigned     roll;
        int unsigned     keep;
        noise = VA_W'(rand_word());
        roll = $urandom_range(0, 99);
        if (mapped_pages.size() == 0 || roll < 4) begin
            return noise;
        end
        va = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
        if (roll < 10) begin
            keep = 39;
        end else if (roll < 25) begin
            keep = 30;
        end else if (roll < 85) begin
            keep = 21;
        end else begin
            keep = PAGE_SHIFT;
        end
        lower = (VA_W'(1) << keep) - 1;
        return (va & ~lower) | (noise & lower);
    endfunction

    function automatic logic [PA_W-1:0] pick_phys();
        case ($urandom_range(0, 9))
            0: return {PA_W{1'b1}};
            1: return '0;
            default: return PA_W'(rand_word());
        endcase
    endfunction

    function automatic logic [ENTRY_W-1:0] pick_flags();
        case ($urandom_range(0, 9))
            0: return {ENTRY_W{1'b1}};
            1: return '0;
            2: return ENTRY_W'(1) << $urandom_range(0, ENTRY_W - 1);
            default: return rand_word();
        endcase
    endfunction

    task automatic write_pool_base(input logic [PBF_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        walk_board.set_pool_base(value);
        setting_count++;
    endtask

    task automatic issue(input logic [VA_W-1:0] va, input logic [PA_W-1:0] pa,
                         input logic [ENTRY_W-1:0] flags);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.virt_addr <= va;
        req_if.phys_addr <= pa;
        req_if.entry_flags <= flags;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        if (walk_board.note_request(va, pa, flags)) begin
            if (mapped_pages.size() < PAGE_LIST_MAX) begin
                mapped_pages.push_back(va);
            end else begin
                mapped_pages[$urandom_range(0, PAGE_LIST_MAX - 1)] = va;
            end
        end
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            issue(pick_va(), pick_phys(), pick_flags());
        end
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        while (walk_board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        for (watch_cycles = 0; watch_cycles < WATCHDOG_CYCLES; watch_cycles++) begin
            @(posedge i_clk);
        end
        $display("FAIL page_table_map_engine_core");
        $finish;
    end

    initial begin
        map_result_t got;
        rx_pace_t    pace;
        int          pace_left;
        rsp_if.ready <= 1'b0;
        pace = RX_STEADY;
        pace_left = 0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                got.status = rsp_if.status;
                got.tables_allocated = rsp_if.tables_allocated;
                got.leaf_entry = rsp_if.leaf_entry;
                walk_board.check_result(got);
                words_seen++;
            end
            if (hold_index < 2 && words_seen >= ((hold_index == 0) ? 150 : 1200)) begin
                hold_index++;
                rsp_if.ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++) begin
                    @(posedge i_clk);
                end
            end
            if (pace_left == 0) begin
                pace = rx_pace_t'($urandom_range(0, 3));
                pace_left = $urandom_range(32, 256);
            end
            pace_left--;
            case (pace)
                RX_STEADY:   rsp_if.ready <= 1'b1;
                RX_LIGHT:    rsp_if.ready <= ($urandom_range(0, 9) < 7);
                RX_PERIODIC: rsp_if.ready <= (pace_left % 3 != 0);
                default:     rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        req_if.valid <= 1'b0;
        req_if.virt_addr <= '0;
        req_if.phys_addr <= '0;
        req_if.entry_flags <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_pool_base('0);

        issue('0, '0, '0);
        issue({VA_W{1'b1}}, {PA_W{1'b1}}, {ENTRY_W{1'b1}});
        issue(48'h0000_0000_1000, 52'h0_0000_1234_5678, 64'h0);
        issue(48'h0000_0020_0000, 52'hF_FFFF_FFFF_F000, 64'h2);
        issue(48'h0000_4000_0000, 52'h0_0000_0000_0FFF, 64'h8000_0000_0000_0000);
        issue(48'h0080_0000_0000, 52'h8_0000_0000_0000, 64'h6);
        issue('0, 52'h0_0000_0000_1000, 64'h1);
        issue(48'hFFFF_FFFF_F000, '0, 64'h7FFF_FFFF_FFFF_FFFF);
        issue(48'h8000_0000_0ABC, 52'h5_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        run_random(800);
        settle();

        write_pool_base({PBF_W{1'b1}});
        run_random(450);
        settle();

        write_pool_base(PBF_W'(rand_word()) | (PBF_W'(1) << 30));
        run_random(150);
        settle();

        write_pool_base('0);
        run_random(550);
        settle();

        walk_board.close_out();
        $display("Sent %0d map requests under %0d pool base settings: %0d mapped, %0d refused.",
                 walk_board.mapped_count + walk_board.refused_count, setting_count,
                 walk_board.mapped_count, walk_board.refused_count);
        $display("%0d tables were taken from the pool; %0d words checked, %0d failures.",
                 walk_board.tables_taken, walk_board.words_checked, walk_board.fail_count);
        if (walk_board.fail_count == 0) begin
            $display("PASS page_table_map_engine_core");
        end else begin
            $display("FAIL page_table_map_engine_core");
        end
        $finish;
    end

endmodule
